/* src/idcb_pkg.sv */
// ----------------------------------------------------------------------------
// idcb_pkg
// Shared types, widths and the anchor table of the inverse-distance blender.
// ----------------------------------------------------------------------------
package idcb_pkg;

  localparam int unsigned TableSize  = 16;
  localparam int unsigned TreeLvls   = 4;     // log2 of TableSize
  localparam int unsigned MinDistQ24 = 16777; // 0.001 in Q.24

  // datapath widths
  localparam int unsigned DiffW    = 17;  // signed Q3.14 difference
  localparam int unsigned SqW      = 32;  // one squared difference
  localparam int unsigned D2W      = 33;  // dx^2 + dy^2
  localparam int unsigned SqInW    = 38;  // (d2 << 4), padded to even
  localparam int unsigned SqRemW   = 21;
  localparam int unsigned SqRootW  = 19;
  localparam int unsigned SqSteps  = SqRootW;
  localparam int unsigned D2sW     = 29;
  localparam int unsigned D4W      = 34;
  localparam int unsigned D4LoW    = 17;
  localparam int unsigned PpW      = 36;
  localparam int unsigned DsumW    = 54;
  localparam int unsigned DenW     = 38;
  localparam int unsigned WQuoW    = 41;  // weight, Q.28
  localparam int unsigned TotW     = 45;
  localparam int unsigned AccW     = 53;
  localparam int unsigned ChanQuoW = 8;

  // lane: diff, square, sum, sqrt cells, partial products, denominator,
  // divider cells, leaf products
  localparam int unsigned LaneLat  = 3 + SqSteps + 2 + WQuoW + 1;

  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [14:0]        strength;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
  } anchor_t;

  typedef struct packed {
    logic [TotW-1:0]        total;
    logic [2:0][AccW-1:0]   acc;
  } leaf_t;

  function automatic anchor_t anchor_at(input logic [3:0] idx);
    anchor_t a;
    case (idx)
      4'd0:    a = '{16'sd13926, 16'sd6554,  15'd4096,  8'd255, 8'd0,   8'd0};
      4'd1:    a = '{16'sd13107, 16'sd11469, 15'd4096,  8'd248, 8'd230, 8'd9};
      4'd2:    a = '{16'sd4915,  16'sd13107, 15'd4096,  8'd0,   8'd242, 8'd28};
      4'd3:    a = '{16'sd1638,  16'sd13107, 15'd7373,  8'd0,   8'd242, 8'd28};
      4'd4:    a = '{16'sd0,     16'sd6554,  15'd8192,  8'd5,   8'd8,   8'd255};
      4'd5:    a = '{16'sd3277,  16'sd4915,  15'd10240, 8'd20,  8'd80,  8'd100};
      4'd6:    a = '{16'sd14746, 16'sd0,     15'd4096,  8'd0,   8'd0,   8'd0};
      4'd7:    a = '{16'sd11469, 16'sd0,     15'd4096,  8'd0,   8'd0,   8'd0};
      4'd8:    a = '{16'sd8192,  16'sd0,     15'd19251, 8'd0,   8'd0,   8'd0};
      4'd9:    a = '{16'sd4915,  16'sd0,     15'd2867,  8'd0,   8'd0,   8'd0};
      4'd10:   a = '{16'sd8192,  16'sd8192,  15'd6963,  8'd151, 8'd69,  8'd3};
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

/* src/idcb_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// idcb_sqrt_cell
// One step of a digit-by-digit integer square root: one root bit per cell.
// ----------------------------------------------------------------------------
module idcb_sqrt_cell (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [idcb_pkg::SqInW-1:0]       rad_i,
  input  logic [idcb_pkg::SqRemW-1:0]      rem_i,
  input  logic [idcb_pkg::SqRootW-1:0]     root_i,
  output logic [idcb_pkg::SqInW-1:0]       rad_o,
  output logic [idcb_pkg::SqRemW-1:0]      rem_o,
  output logic [idcb_pkg::SqRootW-1:0]     root_o
);

  logic [idcb_pkg::SqRemW+1:0] t;
  logic [idcb_pkg::SqRemW+1:0] trial;
  logic                        ge;

  logic [idcb_pkg::SqInW-1:0]   rad_q;
  logic [idcb_pkg::SqRemW-1:0]  rem_q;
  logic [idcb_pkg::SqRootW-1:0] root_q;

  assign t     = {rem_i, rad_i[idcb_pkg::SqInW-1 -: 2]};
  assign trial = (idcb_pkg::SqRemW+2)'({root_i, 2'b01});
  assign ge    = (t >= trial);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_i << 2;
      rem_q  <= ge ? idcb_pkg::SqRemW'(t - trial) : idcb_pkg::SqRemW'(t);
      root_q <= {root_i[idcb_pkg::SqRootW-2:0], ge};
    end
  end

  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

/* src/idcb_div_cell.sv */
// ----------------------------------------------------------------------------
// idcb_div_cell
// One restoring-division step: brings down one dividend bit, one quotient bit.
// ----------------------------------------------------------------------------
module idcb_div_cell #(
  parameter int unsigned DenW = 38,
  parameter int unsigned QuoW = 41
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [DenW-1:0] rem_i,
  input  logic [DenW-1:0] den_i,
  input  logic [QuoW-1:0] quo_i,
  input  logic [QuoW-1:0] num_i,
  output logic [DenW-1:0] rem_o,
  output logic [DenW-1:0] den_o,
  output logic [QuoW-1:0] quo_o,
  output logic [QuoW-1:0] num_o
);

  logic [DenW:0]   t;
  logic            ge;
  logic [DenW-1:0] rem_q, den_q;
  logic [QuoW-1:0] quo_q, num_q;

  assign t  = {rem_i, num_i[QuoW-1]};
  assign ge = (t >= {1'b0, den_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= ge ? DenW'(t - {1'b0, den_i}) : DenW'(t);
      den_q <= den_i;
      quo_q <= {quo_i[QuoW-2:0], ge};
      num_q <= num_i << 1;
    end
  end

  assign rem_o = rem_q;
  assign den_o = den_q;
  assign quo_o = quo_q;
  assign num_o = num_q;

endmodule

/* src/idcb_lane.sv */
// ----------------------------------------------------------------------------
// idcb_lane
// Weight of one anchor: distance, distance^5, strength / (d^5 + 0.001),
// then the weighted colors.
// ----------------------------------------------------------------------------
module idcb_lane (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  idcb_pkg::anchor_t       anchor_i,
  input  logic signed [15:0]      arousal_i,
  input  logic signed [15:0]      valence_i,
  output idcb_pkg::leaf_t         leaf_o
);

  localparam int unsigned SqSteps = idcb_pkg::SqSteps;
  localparam int unsigned WQuoW   = idcb_pkg::WQuoW;
  localparam int unsigned DenW    = idcb_pkg::DenW;

  logic signed [idcb_pkg::DiffW-1:0] dx_q, dy_q;
  logic signed [2*idcb_pkg::DiffW-1:0] px, py;
  logic [idcb_pkg::SqW-1:0] sqx_q, sqy_q;
  logic [idcb_pkg::D2W-1:0] d2_q;
  logic [idcb_pkg::D2sW-1:0] d2s;
  logic [2*idcb_pkg::D2sW-1:0] d2sq;
  logic [idcb_pkg::D4W-1:0] d4_q [SqSteps];

  logic [idcb_pkg::SqInW-1:0]   sq_rad  [SqSteps+1];
  logic [idcb_pkg::SqRemW-1:0]  sq_rem  [SqSteps+1];
  logic [idcb_pkg::SqRootW-1:0] sq_root [SqSteps+1];

  logic [idcb_pkg::PpW-1:0]   ph_q, pl_q;
  logic [idcb_pkg::DsumW-1:0] dsum;
  logic [DenW-1:0]            den_q;

  logic [DenW-1:0]  dv_rem [WQuoW+1];
  logic [DenW-1:0]  dv_den [WQuoW+1];
  logic [WQuoW-1:0] dv_quo [WQuoW+1];
  logic [WQuoW-1:0] dv_num [WQuoW+1];

  logic [2:0][7:0]  col;
  idcb_pkg::leaf_t  leaf_q;

  // differences and squares
  assign px = dx_q * dx_q;
  assign py = dy_q * dy_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q  <= idcb_pkg::DiffW'(arousal_i) - idcb_pkg::DiffW'(anchor_i.cx);
      dy_q  <= idcb_pkg::DiffW'(valence_i) - idcb_pkg::DiffW'(anchor_i.cy);
      sqx_q <= px[idcb_pkg::SqW-1:0];
      sqy_q <= py[idcb_pkg::SqW-1:0];
      d2_q  <= {1'b0, sqx_q} + {1'b0, sqy_q};
    end
  end

  // d^4 runs beside the root cells
  assign d2s  = d2_q[idcb_pkg::D2W-1:4];
  assign d2sq = (2*idcb_pkg::D2sW)'(d2s) * (2*idcb_pkg::D2sW)'(d2s);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d4_q[0] <= d2sq[2*idcb_pkg::D2sW-1:24];
      for (int k = 1; k < SqSteps; k++) d4_q[k] <= d4_q[k-1];
    end
  end

  // root of d2 * 16
  assign sq_rad[0]  = {1'b0, d2_q, 4'b0};
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar s = 0; s < SqSteps; s++) begin : g_sqrt
    idcb_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .rad_i  (sq_rad[s]),
      .rem_i  (sq_rem[s]),
      .root_i (sq_root[s]),
      .rad_o  (sq_rad[s+1]),
      .rem_o  (sq_rem[s+1]),
      .root_o (sq_root[s+1])
    );
  end

  // d^5 in two partial products, then the denominator
  assign dsum = {1'b0, ph_q, 17'b0} + {18'b0, pl_q}
              + (idcb_pkg::DsumW'(idcb_pkg::MinDistQ24) << 16);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q  <= idcb_pkg::PpW'(d4_q[SqSteps-1][idcb_pkg::D4W-1:idcb_pkg::D4LoW])
             * idcb_pkg::PpW'(sq_root[SqSteps]);
      pl_q  <= idcb_pkg::PpW'(d4_q[SqSteps-1][idcb_pkg::D4LoW-1:0])
             * idcb_pkg::PpW'(sq_root[SqSteps]);
      den_q <= dsum[idcb_pkg::DsumW-1:16];
    end
  end

  // (strength << 40) / den; top dividend bits are below den from the start
  assign dv_rem[0] = DenW'(anchor_i.strength[14:1]);
  assign dv_den[0] = den_q;
  assign dv_quo[0] = '0;
  assign dv_num[0] = {anchor_i.strength[0], (WQuoW-1)'(0)};

  for (genvar q = 0; q < WQuoW; q++) begin : g_div
    idcb_div_cell #(
      .DenW (DenW),
      .QuoW (WQuoW)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .rem_i (dv_rem[q]),
      .den_i (dv_den[q]),
      .quo_i (dv_quo[q]),
      .num_i (dv_num[q]),
      .rem_o (dv_rem[q+1]),
      .den_o (dv_den[q+1]),
      .quo_o (dv_quo[q+1]),
      .num_o (dv_num[q+1])
    );
  end

  assign col = {anchor_i.b, anchor_i.g, anchor_i.r};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      leaf_q.total <= idcb_pkg::TotW'(dv_quo[WQuoW]);
      for (int c = 0; c < 3; c++) begin
        leaf_q.acc[c] <= idcb_pkg::AccW'(dv_quo[WQuoW]) * idcb_pkg::AccW'(col[c]);
      end
    end
  end

  assign leaf_o = leaf_q;

endmodule

/* src/inverse_distance_color_blend_core.sv */
// Throughput: one point per cycle unless stalled; the datapath is fully pipelined,
//   one root bit per square-root cell and one quotient bit per divider cell.
// The pipeline stalls only while the output register is full and not taken and
//   the last stage holds a finished item; the whole pipeline then holds still.
// Reset clears the valid bits and the output valid; payload registers keep junk.
// ----------------------------------------------------------------------------
// inverse_distance_color_blend_core
// Shepard blend (power 5) of a fixed table of anchor colors at one 2-D point.
// ----------------------------------------------------------------------------
module inverse_distance_color_blend_core #(
  parameter int unsigned NUM_ANCHORS = 11
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] arousal_i,
  input  logic signed [15:0] valence_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o
);

  localparam int unsigned TableSize = idcb_pkg::TableSize;
  localparam int unsigned QuoW      = idcb_pkg::ChanQuoW;
  localparam int unsigned TotW      = idcb_pkg::TotW;
  localparam int unsigned AccW      = idcb_pkg::AccW;
  // lanes, adder tree, rounding offset, channel dividers
  localparam int unsigned PipeLat   = idcb_pkg::LaneLat + idcb_pkg::TreeLvls + 1 + QuoW;
  localparam int unsigned Last      = PipeLat - 1;

  // Whole pipeline moves as one; it may move whenever the last stage has
  // nowhere to be blocked.
  logic adv;
  logic [PipeLat-1:0] vld_q;
  logic out_valid_q;

  assign adv        = !out_valid_q || out_ready_i || !vld_q[Last];
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PipeLat-2:0], in_valid_i};
    end
  end

  // One lane per anchor, all anchors evaluated in parallel; unused table
  // slots feed zeros into the tree.
  idcb_pkg::leaf_t leaf [TableSize];

  for (genvar i = 0; i < TableSize; i++) begin : g_lane
    if (i < NUM_ANCHORS) begin : g_on
      idcb_lane u_lane (
        .clk_i     (clk_i),
        .en_i      (adv),
        .anchor_i  (idcb_pkg::anchor_at(4'(i))),
        .arousal_i (arousal_i),
        .valence_i (valence_i),
        .leaf_o    (leaf[i])
      );
    end else begin : g_off
      assign leaf[i] = '0;
    end
  end

  // Registered binary adder tree, heap order: node k has children 2k+1, 2k+2;
  // indexes past the internal nodes are the leaves.
  idcb_pkg::leaf_t node_q [TableSize-1];

  for (genvar k = 0; k < TableSize - 1; k++) begin : g_tree
    idcb_pkg::leaf_t lhs, rhs;
    if (2*k + 1 >= TableSize - 1) begin : g_leaf
      assign lhs = leaf[2*k + 1 - (TableSize - 1)];
      assign rhs = leaf[2*k + 2 - (TableSize - 1)];
    end else begin : g_node
      assign lhs = node_q[2*k + 1];
      assign rhs = node_q[2*k + 2];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        node_q[k].total <= lhs.total + rhs.total;
        for (int c = 0; c < 3; c++) node_q[k].acc[c] <= lhs.acc[c] + rhs.acc[c];
      end
    end
  end

  // Round to nearest: add half the total before the divide.
  logic [2:0][AccW-1:0] x_q;
  logic [TotW-1:0]      tot_q;
  logic                 zero_q;
  logic [QuoW-1:0]      zero_dly_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        x_q[c] <= node_q[0].acc[c] + AccW'(node_q[0].total >> 1);
      end
      tot_q      <= node_q[0].total;
      zero_q     <= (node_q[0].total == '0);
      zero_dly_q <= {zero_dly_q[QuoW-2:0], zero_q};
    end
  end

  // Channel dividers: the quotient never exceeds 255, so eight cells suffice
  // and the upper dividend bits start as the partial remainder.
  logic [2:0][QuoW-1:0] chan;

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [TotW-1:0] rem [QuoW+1];
    logic [TotW-1:0] den [QuoW+1];
    logic [QuoW-1:0] quo [QuoW+1];
    logic [QuoW-1:0] num [QuoW+1];

    assign rem[0] = x_q[c][AccW-1:QuoW];
    assign den[0] = tot_q;
    assign quo[0] = '0;
    assign num[0] = x_q[c][QuoW-1:0];

    for (genvar s = 0; s < QuoW; s++) begin : g_cell
      idcb_div_cell #(
        .DenW (TotW),
        .QuoW (QuoW)
      ) u_cell (
        .clk_i (clk_i),
        .en_i  (adv),
        .rem_i (rem[s]),
        .den_i (den[s]),
        .quo_i (quo[s]),
        .num_i (num[s]),
        .rem_o (rem[s+1]),
        .den_o (den[s+1]),
        .quo_o (quo[s+1]),
        .num_o (num[s+1])
      );
    end

    assign chan[c] = zero_dly_q[QuoW-1] ? '0 : quo[QuoW];
  end

  // Output register: parts the pipeline from the consumer.
  logic [7:0] red_q, green_q, blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && vld_q[Last]) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && vld_q[Last]) begin
      red_q   <= chan[0];
      green_q <= chan[1];
      blue_q  <= chan[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

  // A held result with a finished item behind it must freeze the pipeline.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i && vld_q[Last] |-> !in_ready_o)
    else $error("pipeline advanced over a blocked result");

  // A result only appears when the last stage held an item.
  a_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(vld_q[Last]))
    else $error("result without a finished item");

  // Every weight is positive, so the total is never zero.
  a_tot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[Last] |-> !zero_dly_q[QuoW-1])
    else $error("zero weight total");

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the inverse-distance color blender: drives points,
// predicts each blended color in 64-bit integer math and compares in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumAnchors = 11;
  localparam int unsigned NumItems   = 500;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  // integer floor square root
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // blended color for one point
  function automatic color_t blend_color(input logic signed [15:0] ar,
                                         input logic signed [15:0] va);
    longint unsigned   total, w, d2, root_d, d2s, d4, d5;
    longint unsigned   acc [3];
    longint unsigned   ch;
    longint signed     dx, dy;
    idcb_pkg::anchor_t an;
    color_t            res;
    total = 0;
    acc   = '{0, 0, 0};
    for (int i = 0; i < NumAnchors && i < idcb_pkg::TableSize; i++) begin
      an     = idcb_pkg::anchor_at(4'(i));
      dx     = longint'(ar) - longint'(an.cx);
      dy     = longint'(va) - longint'(an.cy);
      d2     = longint'(dx * dx) + longint'(dy * dy);
      root_d = floor_sqrt(d2 << 4);
      d2s    = d2 >> 4;
      d4     = (d2s * d2s) >> 24;
      d5     = (d4 * root_d) >> 16;
      w      = (longint'(an.strength) << 40) / (d5 + idcb_pkg::MinDistQ24);
      total += w;
      acc[0] += w * an.r;
      acc[1] += w * an.g;
      acc[2] += w * an.b;
    end
    for (int c = 0; c < 3; c++) begin
      ch = (total != 0) ? (acc[c] + (total >> 1)) / total : 0;
      if (ch > 255) ch = 255;
      if (c == 0) res.red = ch[7:0];
      else if (c == 1) res.green = ch[7:0];
      else res.blue = ch[7:0];
    end
    return res;
  endfunction

  class color_board;
    color_t pending[$];
    int     errors = 0;

    function void note_point(logic signed [15:0] ar, logic signed [15:0] va);
      pending = {pending, blend_color(ar, va)};
    endfunction

    function void check_color(color_t got);
      color_t exp_c;
      if (pending.size() == 0) begin
        $display("%0t: unexpected color %0d/%0d/%0d", $realtime,
                 got.red, got.green, got.blue);
        errors++;
        return;
      end
      exp_c = pending.pop_front();
      if (got.red !== exp_c.red) begin
        $display("%0t: red exp %0d got %0d", $realtime, exp_c.red, got.red);
        errors++;
      end
      if (got.green !== exp_c.green) begin
        $display("%0t: green exp %0d got %0d", $realtime, exp_c.green, got.green);
        errors++;
      end
      if (got.blue !== exp_c.blue) begin
        $display("%0t: blue exp %0d got %0d", $realtime, exp_c.blue, got.blue);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] arousal_i = '0;
  logic signed [15:0] valence_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [7:0]         red_o, green_o, blue_o;

  color_board board = new();
  bit         quiet;      // no idling on either side
  bit         hold_off;   // long receiver stall
  bit         send_done = 1'b0;

  inverse_distance_color_blend_core #(.NUM_ANCHORS(NumAnchors)) dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // idle with a probability of about 13 percent unless in a quiet stretch
  function automatic bit take_gap();
    return !quiet && ($urandom_range(99) < 13);
  endfunction

  // offer one point; valid stays up until it is taken
  task automatic send_point(input logic signed [15:0] ar,
                            input logic signed [15:0] va);
    while (take_gap()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    arousal_i  <= ar;
    valence_i  <= va;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_point(ar, va);
  endtask

  // stimulus
  initial begin
    logic signed [15:0] corners [4];
    idcb_pkg::anchor_t  an;
    corners = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // extremes of both fields
    foreach (corners[i]) foreach (corners[j]) send_point(corners[i], corners[j]);
    // exactly on a few anchor centers: weight near its maximum
    for (int k = 0; k < 11; k += 2) begin
      an = idcb_pkg::anchor_at(4'(k));
      send_point(an.cx, an.cy);
    end
    for (int n = 0; n < NumItems; n++) begin
      quiet = (n >= 40 && n < 140);
      case ($urandom_range(3))
        0: send_point(16'($urandom), 16'($urandom));
        1: send_point(16'($urandom_range(16384)), 16'($urandom_range(16384)));
        2: begin  // close to an anchor
          an = idcb_pkg::anchor_at(4'($urandom_range(10)));
          send_point(an.cx + $signed(16'($urandom_range(400))) - 16'sd200,
                     an.cy + $signed(16'($urandom_range(400))) - 16'sd200);
        end
        default: send_point(corners[$urandom_range(3)], 16'($urandom));
      endcase
    end
    in_valid_i <= 1'b0;
    send_done  = 1'b1;
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int cyc;
    cyc = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (out_valid_o && out_ready_i)
        board.check_color('{red_o, green_o, blue_o});
      hold_off = (cyc >= 300 && cyc < 600);
      out_ready_i <= !hold_off && !take_gap();
    end
  end

  // end of run
  initial begin
    @(posedge send_done);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #200us;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* sim.f */
src/idcb_pkg.sv
src/idcb_sqrt_cell.sv
src/idcb_div_cell.sv
src/idcb_lane.sv
src/inverse_distance_color_blend_core.sv
bench/tb.sv
